// File: rtl/motor_fault_protection_core_macros.svh
// ----------------------------------------------------------------------------
// Motor fault protection assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FAULT_PROTECTION_CORE_MACROS_SVH
`define MOTOR_FAULT_PROTECTION_CORE_MACROS_SVH

// A same-cycle implication checked at every clock edge outside reset.
`define MFP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A next-cycle implication checked at every clock edge outside reset.
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// Motor fault protection package
// Register indexes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfp_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] REG_UNDERVOLTAGE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_OVERVOLTAGE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OVERCURRENT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OC_TIME = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STALL_CURRENT = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_STALL_SPEED = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_STALL_TIME = 3'd6;

	// Register values after reset.
	localparam logic [15:0] RST_UNDERVOLTAGE = 16'd0;
	localparam logic [15:0] RST_OVERVOLTAGE = 16'd65535;
	localparam logic [15:0] RST_OVERCURRENT = 16'd32768;
	localparam logic [31:0] RST_OC_TIME = 32'd1000;
	localparam logic [15:0] RST_STALL_CURRENT = 16'd32768;
	localparam logic [15:0] RST_STALL_SPEED = 16'd0;
	localparam logic [31:0] RST_STALL_TIME = 32'd1000000;

	typedef struct packed {
		logic [15:0] undervoltage_mv;
		logic [15:0] overvoltage_mv;
		logic [15:0] overcurrent_ma;
		logic [31:0] overcurrent_time_us;
		logic [15:0] stall_current_ma;
		logic [15:0] stall_speed_lim;
		logic [31:0] stall_time_us;
	} cfg_t;

endpackage

// File: rtl/motor_fault_protection_core.sv
// ----------------------------------------------------------------------------
// Motor fault protection core
// Voltage window, overcurrent timer and stall timer on a sample stream.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the input register, then the result
// register, where its result can be taken.
// Throughput: one item per cycle while out_ready is high; the timer update
// between the input register and the result register adds no register stage.
// Reset: arst_n clears both timers, the pipeline valids and loads the limit
// registers with their default values.
`timescale 1ns / 1ps
`include "motor_fault_protection_core_macros.svh"

module motor_fault_protection_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mfp_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic        [15:0]            bus_voltage_mv,
	input  logic signed [15:0]            phase_a_ma,
	input  logic signed [15:0]            phase_b_ma,
	input  logic signed [15:0]            phase_c_ma,
	input  logic signed [15:0]            rotor_speed,
	input  logic        [15:0]            elapsed_us,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          undervolt_fault,
	output logic                          overvolt_fault,
	output logic                          overcurrent_fault,
	output logic                          stall_fault,
	output logic        [15:0]            peak_current_ma
);
	import mfp_pkg::*;

	cfg_t cfg;

	logic               valid_s1;
	logic        [15:0] bus_voltage_s1;
	logic signed [15:0] phase_a_s1;
	logic signed [15:0] phase_b_s1;
	logic signed [15:0] phase_c_s1;
	logic signed [15:0] speed_s1;
	logic        [15:0] elapsed_s1;

	logic        out_valid_q;
	logic        undervolt_q;
	logic        overvolt_q;
	logic        overcurrent_q;
	logic        stall_q;
	logic [15:0] peak_q;

	logic        adv_out;
	logic        step;
	logic [15:0] peak_ma;
	logic [15:0] speed_mag;
	logic        uv;
	logic        ov;
	logic        oc_cond;
	logic        stall_cond;
	logic        oc_fault;
	logic        st_fault;

	mfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The item in the input register moves on when the result register is free.
	assign adv_out = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_out;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bus_voltage_s1 <= bus_voltage_mv;
			phase_a_s1 <= phase_a_ma;
			phase_b_s1 <= phase_b_ma;
			phase_c_s1 <= phase_c_ma;
			speed_s1 <= rotor_speed;
			elapsed_s1 <= elapsed_us;
		end
	end

	mfp_peak u_peak (
		.phase_a_ma  (phase_a_s1),
		.phase_b_ma  (phase_b_s1),
		.phase_c_ma  (phase_c_s1),
		.rotor_speed (speed_s1),
		.peak_ma     (peak_ma),
		.speed_mag   (speed_mag)
	);

	// An item with zero elapsed time leaves state alone and flags nothing.
	assign step = adv_out && (elapsed_s1 != 16'd0);

	// Voltage window; undervoltage wins when both limits are crossed.
	assign uv = step && (bus_voltage_s1 < cfg.undervoltage_mv);
	assign ov = step && !(bus_voltage_s1 < cfg.undervoltage_mv) &&
		(bus_voltage_s1 > cfg.overvoltage_mv);

	assign oc_cond = peak_ma > cfg.overcurrent_ma;
	assign stall_cond = (peak_ma > cfg.stall_current_ma) &&
		(speed_mag < cfg.stall_speed_lim);

	mfp_timer u_oc_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cond       (oc_cond),
		.elapsed_us (elapsed_s1),
		.limit_us   (cfg.overcurrent_time_us),
		.fault      (oc_fault)
	);

	mfp_timer u_stall_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cond       (stall_cond),
		.elapsed_us (elapsed_s1),
		.limit_us   (cfg.stall_time_us),
		.fault      (st_fault)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			undervolt_q <= uv;
			overvolt_q <= ov;
			overcurrent_q <= oc_fault;
			stall_q <= st_fault;
			peak_q <= peak_ma;
		end
	end

	assign out_valid = out_valid_q;
	assign undervolt_fault = undervolt_q;
	assign overvolt_fault = overvolt_q;
	assign overcurrent_fault = overcurrent_q;
	assign stall_fault = stall_q;
	assign peak_current_ma = peak_q;

	// Checks on the pipeline control and the voltage window.
	`MFP_ASSERT_IMPL(a_volt_excl, out_valid_q, !(undervolt_q && overvolt_q), "both voltage faults set")
	`MFP_ASSERT_IMPL(a_ready_empty, !valid_s1, in_ready, "input register empty but not ready")
	`MFP_ASSERT_IMPL(a_hold_full, valid_s1 && out_valid_q && !out_ready, !in_ready, "ready while both stages are blocked")
	`MFP_ASSERT_NEXT(a_load_s1, in_valid && in_ready, valid_s1, "accepted item missing from input register")

endmodule

// File: rtl/mfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Motor fault protection configuration registers
// Holds the seven limit registers written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mfp_pkg::CfgDataW-1:0]  cfg_wdata,
	output mfp_pkg::cfg_t                 cfg
);
	import mfp_pkg::*;

	cfg_t cfg_q;

	// Decode the index; an index with no register behind it is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.undervoltage_mv <= RST_UNDERVOLTAGE;
			cfg_q.overvoltage_mv <= RST_OVERVOLTAGE;
			cfg_q.overcurrent_ma <= RST_OVERCURRENT;
			cfg_q.overcurrent_time_us <= RST_OC_TIME;
			cfg_q.stall_current_ma <= RST_STALL_CURRENT;
			cfg_q.stall_speed_lim <= RST_STALL_SPEED;
			cfg_q.stall_time_us <= RST_STALL_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNDERVOLTAGE: cfg_q.undervoltage_mv <= cfg_wdata[15:0];
				REG_OVERVOLTAGE: cfg_q.overvoltage_mv <= cfg_wdata[15:0];
				REG_OVERCURRENT: cfg_q.overcurrent_ma <= cfg_wdata[15:0];
				REG_OC_TIME: cfg_q.overcurrent_time_us <= cfg_wdata[31:0];
				REG_STALL_CURRENT: cfg_q.stall_current_ma <= cfg_wdata[15:0];
				REG_STALL_SPEED: cfg_q.stall_speed_lim <= cfg_wdata[15:0];
				REG_STALL_TIME: cfg_q.stall_time_us <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/mfp_peak.sv
// ----------------------------------------------------------------------------
// Motor fault protection magnitude unit
// Takes the largest absolute phase current and the absolute rotor speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_peak (
	input  logic signed [15:0] phase_a_ma,
	input  logic signed [15:0] phase_b_ma,
	input  logic signed [15:0] phase_c_ma,
	input  logic signed [15:0] rotor_speed,
	output logic        [15:0] peak_ma,
	output logic        [15:0] speed_mag
);
	import mfp_pkg::*;

	// Absolute value; the most negative code maps to 32768, which still fits.
	function automatic logic [15:0] mag16(input logic [15:0] x);
		mag16 = x[15] ? (~x + 16'd1) : x;
	endfunction

	logic [15:0] mag_a;
	logic [15:0] mag_b;
	logic [15:0] mag_c;
	logic [15:0] max_ab;

	assign mag_a = mag16(phase_a_ma);
	assign mag_b = mag16(phase_b_ma);
	assign mag_c = mag16(phase_c_ma);

	// Two compares pick the largest of the three magnitudes.
	assign max_ab = (mag_b > mag_a) ? mag_b : mag_a;
	assign peak_ma = (mag_c > max_ab) ? mag_c : max_ab;
	assign speed_mag = mag16(rotor_speed);

endmodule

// File: rtl/mfp_timer.sv
// ----------------------------------------------------------------------------
// Motor fault protection fault timer
// Accumulates elapsed time while a condition holds and flags its limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        cond,
	input  logic [15:0] elapsed_us,
	input  logic [31:0] limit_us,
	output logic        fault
);
	import mfp_pkg::*;

	logic [31:0] timer_q;
	logic [32:0] sum;
	logic [31:0] next_timer;

	// Saturating add: a carry out pins the timer at its maximum.
	assign sum = {1'b0, timer_q} + {17'd0, elapsed_us};
	assign next_timer = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

	// The fault looks at the timer value after this item's update.
	assign fault = step && cond && (next_timer >= limit_us);

	// Timer advances or clears only for an item that is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= 32'd0;
		end else if (step) begin
			timer_q <= cond ? next_timer : 32'd0;
		end
	end

endmodule
